### design/kpsd_pkg.sv
`timescale 1ns / 1ps

package kpsd_pkg;

  localparam int ROWS_DEF    = 4;
  localparam int COLUMNS_DEF = 4;
  localparam int ROW_LINES_W = 4;
  localparam int HIST_W      = 8;
  localparam int DRIVE_W     = 4;
  localparam int KEY_IDX_W   = 4;
  localparam int KEY_VAL_W   = 4;
  localparam int KEY_CHAR_W  = 7;
  localparam int LEGEND_N    = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [HIST_W-1:0] PRESS_MASK_RST      = 8'b1100_0111;
  localparam logic [HIST_W-1:0] PRESS_PATTERN_RST   = 8'b0000_0111;
  localparam logic [HIST_W-1:0] RELEASE_MASK_RST    = 8'b1110_0011;
  localparam logic [HIST_W-1:0] RELEASE_PATTERN_RST = 8'b1110_0000;
  localparam logic [HIST_W-1:0] HIST_FULL           = 8'hFF;
  localparam logic [HIST_W-1:0] HIST_EMPTY          = 8'h00;

  // register indexes
  localparam logic [1:0] REG_PRESS_MASK      = 2'd0;
  localparam logic [1:0] REG_PRESS_PATTERN   = 2'd1;
  localparam logic [1:0] REG_RELEASE_MASK    = 2'd2;
  localparam logic [1:0] REG_RELEASE_PATTERN = 2'd3;

  // commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [KEY_VAL_W-1:0] LEGEND_VALUE [LEGEND_N][LEGEND_N] = '{
    '{4'h1, 4'h2, 4'h3, 4'hA},
    '{4'h4, 4'h5, 4'h6, 4'hB},
    '{4'h7, 4'h8, 4'h9, 4'hC},
    '{4'hF, 4'h0, 4'hE, 4'hD}
  };

  localparam logic [KEY_CHAR_W-1:0] LEGEND_CHAR [LEGEND_N][LEGEND_N] = '{
    '{7'h31, 7'h32, 7'h33, 7'h41},
    '{7'h34, 7'h35, 7'h36, 7'h42},
    '{7'h37, 7'h38, 7'h39, 7'h43},
    '{7'h2A, 7'h30, 7'h23, 7'h44}
  };

  typedef struct packed {
    logic [HIST_W-1:0] press_mask;
    logic [HIST_W-1:0] press_pattern;
    logic [HIST_W-1:0] release_mask;
    logic [HIST_W-1:0] release_pattern;
  } kpsd_cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]    column_drive;
    logic                  key_valid;
    logic [KEY_IDX_W-1:0]  key_index;
    logic [KEY_VAL_W-1:0]  key_value;
    logic [KEY_CHAR_W-1:0] key_char;
  } kpsd_result_t;

endpackage

### design/kpsd_cfg_regs.sv
`timescale 1ns / 1ps

module kpsd_cfg_regs
  import kpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output kpsd_cfg_t             cfg
);

  kpsd_cfg_t  cfg_r;
  kpsd_cfg_t  cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic [HIST_W-1:0] rd_val;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PRESS_MASK:      cfg_nxt.press_mask      = cfg_pwdata[HIST_W-1:0];
        REG_PRESS_PATTERN:   cfg_nxt.press_pattern   = cfg_pwdata[HIST_W-1:0];
        REG_RELEASE_MASK:    cfg_nxt.release_mask    = cfg_pwdata[HIST_W-1:0];
        REG_RELEASE_PATTERN: cfg_nxt.release_pattern = cfg_pwdata[HIST_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESS_MASK:      rd_val = cfg_r.press_mask;
      REG_PRESS_PATTERN:   rd_val = cfg_r.press_pattern;
      REG_RELEASE_MASK:    rd_val = cfg_r.release_mask;
      REG_RELEASE_PATTERN: rd_val = cfg_r.release_pattern;
    endcase
  end

  assign cfg_prdata = {{(CFG_DATA_W-HIST_W){1'b0}}, rd_val};
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_mask      <= PRESS_MASK_RST;
      cfg_r.press_pattern   <= PRESS_PATTERN_RST;
      cfg_r.release_mask    <= RELEASE_MASK_RST;
      cfg_r.release_pattern <= RELEASE_PATTERN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/kpsd_key_array.sv
`timescale 1ns / 1ps

module kpsd_key_array
  import kpsd_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   command,
  input  logic [ROW_LINES_W-1:0] row_lines,
  input  kpsd_cfg_t              cfg,
  output kpsd_result_t           result
);

  localparam int NKEYS = ROWS * COLUMNS;
  localparam int CW    = $clog2(COLUMNS);

  logic [HIST_W-1:0] hist_r   [NKEYS];
  logic [HIST_W-1:0] hist_nxt [NKEYS];
  logic [NKEYS-1:0]  press_r, press_nxt;
  logic [NKEYS-1:0]  rel_r, rel_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [ROWS-1:0]   hit_row;
  logic [NKEYS-1:0]  both;
  logic [NKEYS-1:0]  sel;
  logic              tick;

  assign tick = (command == CMD_TICK);

  // highest active row among the matrix rows wins; row bits past ROWS are ignored
  always_comb begin
    hit_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (((row_lines >> r) & ROW_LINES_W'(1)) != '0) begin
        hit_row    = '0;
        hit_row[r] = 1'b1;
      end
    end
  end

  // first completed key in row-major order, isolated as a one-hot
  assign both = press_r & rel_r;
  assign sel  = both & (~both + NKEYS'(1));

  always_comb begin
    logic [HIST_W-1:0] h;
    logic              pm, rm;
    h         = '0;
    pm        = 1'b0;
    rm        = 1'b0;
    press_nxt = press_r;
    rel_nxt   = rel_r;
    for (int k = 0; k < NKEYS; k++) hist_nxt[k] = hist_r[k];
    if (tick) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          h = hist_r[r*COLUMNS+c];
          if (CW'(c) == col_r) h = {h[HIST_W-2:0], hit_row[r]};
          pm = (h & cfg.press_mask) == cfg.press_pattern;
          if (pm) h = HIST_FULL;
          rm = (h & cfg.release_mask) == cfg.release_pattern;
          if (rm) h = HIST_EMPTY;
          hist_nxt[r*COLUMNS+c]  = h;
          press_nxt[r*COLUMNS+c] = press_r[r*COLUMNS+c] | pm;
          rel_nxt[r*COLUMNS+c]   = rel_r[r*COLUMNS+c] | rm;
        end
      end
    end else begin
      // drop both flags of the key handed out
      press_nxt = press_r & ~sel;
      rel_nxt   = rel_r & ~sel;
    end
  end

  assign col_nxt = !tick ? col_r :
                   (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + CW'(1);

  always_comb begin
    result = '0;
    for (int i = 0; i < DRIVE_W; i++) begin
      result.column_drive[i] = (int'(col_nxt) == i);
    end
    if (!tick) begin
      result.key_valid = |both;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          if (sel[r*COLUMNS+c]) begin
            result.key_index = result.key_index | KEY_IDX_W'(r*COLUMNS+c);
            if (r < LEGEND_N && c < LEGEND_N) begin
              result.key_value = result.key_value |
                                 LEGEND_VALUE[r % LEGEND_N][c % LEGEND_N];
              result.key_char  = result.key_char |
                                 LEGEND_CHAR[r % LEGEND_N][c % LEGEND_N];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NKEYS; k++) hist_r[k] <= HIST_EMPTY;
      press_r <= '0;
      rel_r   <= '0;
      col_r   <= '0;
    end else if (en) begin
      for (int k = 0; k < NKEYS; k++) hist_r[k] <= hist_nxt[k];
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

### design/keypad_scan_debounce.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless out_stall holds the result register;
// a request is held in the input register and resolved in one pass into the
// result register, which drives the out_ ports.
// Reset (rst_n low, synchronous): histories and flags clear, column counter at 0,
// configuration registers return to their default masks and patterns.

module keypad_scan_debounce
  import kpsd_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic [ROW_LINES_W-1:0] in_row_lines,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DRIVE_W-1:0]     out_column_drive,
  output logic                   out_key_valid,
  output logic [KEY_IDX_W-1:0]   out_key_index,
  output logic [KEY_VAL_W-1:0]   out_key_value,
  output logic [KEY_CHAR_W-1:0]  out_key_char,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  kpsd_cfg_t    cfg;
  kpsd_result_t res;
  kpsd_result_t res_r;

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_cmd_r;
  logic [ROW_LINES_W-1:0] s1_rows_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   advance;
  logic                   in_take;

  kpsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  kpsd_key_array #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .command   (s1_cmd_r),
    .row_lines (s1_rows_r),
    .cfg       (cfg),
    .result    (res)
  );

  // move the held request on when the result register frees up
  assign advance       = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = s1_valid_r & ~advance;
  assign in_take       = in_valid & ~in_stall;
  assign s1_valid_nxt  = in_take | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_command;
      s1_rows_r <= in_row_lines;
    end
    if (advance) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_column_drive = res_r.column_drive;
  assign out_key_valid    = res_r.key_valid;
  assign out_key_index    = res_r.key_index;
  assign out_key_value    = res_r.key_value;
  assign out_key_char     = res_r.key_char;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty request register");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("held request did not reach the result register");

  a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_column_drive))
    else $error("column drive not one-hot");

  a_no_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_key_valid) |->
      (out_key_index == '0 && out_key_value == '0 && out_key_char == '0))
    else $error("key fields set without a key event");

endmodule
